FILE: design/asu_pkg.sv
// Shared types and fixed widths of the arcsine series unit.
package asu_pkg;

  localparam int unsigned XW   = 32;  // argument and angle width
  localparam int unsigned SIGW = 4;   // precision register width
  localparam int unsigned DW   = 64;  // internal datapath width
  localparam int unsigned KW   = 6;   // decade and digit counters
  localparam int unsigned KMAX = 40;  // decade search limit

  // divide / square root unit control and status
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_sts_t;

endpackage

FILE: design/asu_in_if.sv
// Argument channel of the arcsine series unit.
interface asu_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [asu_pkg::XW-1:0]    x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

FILE: design/asu_out_if.sv
// Result channel of the arcsine series unit.
interface asu_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [asu_pkg::XW-1:0]    angle;
  logic                             invalid;

  modport source (output valid, output angle, output invalid, input ready);
  modport sink   (input valid, input angle, input invalid, output ready);
endinterface

FILE: design/arcsine_series_unit.sv
// Top level of the arcsine series unit: sequencer, shared multiplier, registers.
//
//  channel    dir  handshake        payload
//  x_in       in   valid/ready      x_value  (signed Q2.FRAC_BITS)
//  res_out    out  valid/ready      angle (signed Q2.FRAC_BITS), invalid
//  cfg        in   cfg_we_i         cfg_wdata_i -> sig_digits
//
// One argument at a time; ready only in IDLE. Zero, |x| >= 1 and |x| = 1/2
// skip the series and go from CLASS straight to FIN. A term costs two divider
// passes for asin, one for atan, MAX_TERMS terms at most; the atan path adds a
// square root and a quotient pass, and one more pass with a reduction; the
// epsilon search runs once. Reset clears sequencer and valid, sig_digits to 6.
// A held result stalls the next one in FIN; x_in is not taken meanwhile.
module arcsine_series_unit #(
  parameter int unsigned FRAC_BITS = 30,
  parameter int unsigned MAX_TERMS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  asu_in_if.sink                       x_in,
  asu_out_if.source                    res_out,
  input  logic                         cfg_we_i,
  input  logic [asu_pkg::SIGW-1:0]     cfg_wdata_i
);

  localparam int unsigned DEN_W = $clog2(2 * MAX_TERMS + 4);
  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);
  localparam int unsigned RSH   = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam logic [63:0] HALFR = (FRAC_BITS < 30) ? (64'd1 << (RSH - 1)) : 64'd0;
  localparam logic [63:0] ONE    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] ONE_SQ = ONE << FRAC_BITS;
  localparam logic [63:0] PI2    = (64'd1686629713 + HALFR) >> RSH;
  localparam logic [63:0] PI6    = (64'd562209904 + HALFR) >> RSH;
  localparam logic [63:0] SQ3    = (64'd1859775393 + HALFR) >> RSH;
  localparam logic [63:0] PI2M6  = PI2 - PI6;
  localparam logic [63:0] RED1   = 2 * ONE - SQ3;
  localparam logic [63:0] LIM71  = 64'd71 * ONE;

  typedef enum logic [26:0] {
    S_IDLE     = 27'd1 << 0,
    S_CLASS    = 27'd1 << 1,
    S_SQ_START = 27'd1 << 2,
    S_SQ_WAIT  = 27'd1 << 3,
    S_T_WAIT   = 27'd1 << 4,
    S_AT_SEL   = 27'd1 << 5,
    S_AT_R2    = 27'd1 << 6,
    S_AT_R1M   = 27'd1 << 7,
    S_AT_R1D   = 27'd1 << 8,
    S_AT_INIT  = 27'd1 << 9,
    S_AT_X2    = 27'd1 << 10,
    S_AT_PW    = 27'd1 << 11,
    S_AT_LOOP  = 27'd1 << 12,
    S_AT_Q     = 27'd1 << 13,
    S_AS_X2    = 27'd1 << 14,
    S_AS_PW    = 27'd1 << 15,
    S_AS_LOOP  = 27'd1 << 16,
    S_AS_Q     = 27'd1 << 17,
    S_AS_T     = 27'd1 << 18,
    S_AS_FD    = 27'd1 << 19,
    S_AS_FQ    = 27'd1 << 20,
    S_PWN      = 27'd1 << 21,
    S_EP_K     = 27'd1 << 22,
    S_EP_P     = 27'd1 << 23,
    S_EP_D     = 27'd1 << 24,
    S_CHK      = 27'd1 << 25,
    S_FIN      = 27'd1 << 26
  } state_e;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] x_sign_q(input logic [63:0] q, input logic n);
    x_sign_q = n ? -$signed(q) : $signed(q);
  endfunction

  state_e state_q;

  logic [asu_pkg::SIGW-1:0] sig_q;
  logic [31:0]              ax_q;
  logic                     neg_q, finv_q;
  logic signed [63:0]       r_q, res_q, prev_q, x2_q, pw_q, t_q, frac_q;
  logic [63:0]              eps_q, ev_q, p_q;
  logic [DEN_W-1:0]         den_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [asu_pkg::KW-1:0]   k_q, e_q, i_q;
  logic [1:0]               mode_q;
  logic                     alt_q, have_q, path_q, tsgn_q;

  // shared multiplier: sign-magnitude, raw product registered
  logic [31:0]              ma, mb;
  logic                     mn;
  logic [63:0]              prod_q;
  logic                     pneg_q;
  logic signed [63:0]       fxm;
  logic [31:0]              prod_fx;
  logic [63:0]              t_mag, pw_mag, x2_mag;

  // divider control
  asu_pkg::ds_cmd_t         ds_cmd;
  asu_pkg::ds_sts_t         ds_sts;
  logic [63:0]              ds_a, ds_b, ds_res;

  logic [63:0]              ax64, ax100, diff_mag;
  logic signed [63:0]       num, qs;
  logic                     ep_more, pw_more, go_on;

  logic                     ovalid_q, finv_out_q;
  logic signed [31:0]       angle_q;

  assign ax64    = {32'd0, ax_q};
  assign ax100   = (ax64 << 6) + (ax64 << 5) + (ax64 << 2);
  assign prod_fx = prod_q[FRAC_BITS +: 32];
  assign fxm     = pneg_q ? -$signed(prod_q >> FRAC_BITS) : $signed(prod_q >> FRAC_BITS);
  assign num     = fxm - $signed(ONE);
  assign qs      = x_sign_q(ds_res, pw_q[63] ^ alt_q);
  assign diff_mag = mag(res_q - prev_q);
  assign go_on   = (diff_mag >= eps_q) && (cnt_q < CNT_W'(MAX_TERMS));
  assign ep_more = (ev_q < ONE) && (k_q < asu_pkg::KW'(asu_pkg::KMAX));
  assign pw_more = (i_q < e_q) && (p_q <= ONE);
  assign t_mag   = mag(t_q);
  assign pw_mag  = mag(pw_q);
  assign x2_mag  = mag(x2_q);

  always_comb begin
    ma = '0;
    mb = '0;
    mn = 1'b0;
    case (state_q)
      S_CLASS: begin
        ma = ax_q;
        mb = ax_q;
      end
      S_AT_SEL: begin
        ma = SQ3[31:0];
        mb = t_mag[31:0];
        mn = t_q[63];
      end
      S_AT_INIT: begin
        ma = t_mag[31:0];
        mb = t_mag[31:0];
      end
      S_AT_X2: begin
        ma = prod_fx;
        mb = t_mag[31:0];
        mn = pneg_q ^ t_q[63];
      end
      S_AS_X2: begin
        ma = ax_q;
        mb = prod_fx;
        mn = pneg_q;
      end
      S_AT_Q, S_AS_FQ: begin
        ma = pw_mag[31:0];
        mb = x2_mag[31:0];
        mn = pw_q[63] ^ x2_q[63];
      end
      S_AS_Q: begin
        ma = frac_q[31:0];
        mb = ds_res[31:0];
      end
      S_AS_T: begin
        ma = frac_q[31:0];
        mb = 32'(den_q) + 32'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, ma} * {32'd0, mb};
    pneg_q <= mn;
  end

  always_comb begin
    ds_cmd = '{start: 1'b0, is_sqrt: 1'b0};
    ds_a   = '0;
    ds_b   = '0;
    case (state_q)
      S_SQ_START: begin
        ds_cmd = '{start: 1'b1, is_sqrt: 1'b1};
        ds_a   = ONE_SQ - prod_q;
      end
      S_SQ_WAIT: begin
        ds_cmd.start = ds_sts.done;
        ds_a = ds_res << FRAC_BITS;
        ds_b = ax64;
      end
      S_AT_SEL: begin
        ds_cmd.start = (t_q != 0) && (t_q >= $signed(ONE));
        ds_a = ONE_SQ;
        ds_b = t_q;
      end
      S_AT_R1M: begin
        ds_cmd.start = 1'b1;
        ds_a = mag(num) << FRAC_BITS;
        ds_b = SQ3 + t_q;
      end
      S_AT_LOOP: begin
        ds_cmd.start = 1'b1;
        ds_a = pw_mag;
        ds_b = 64'(den_q);
      end
      S_AS_LOOP: begin
        ds_cmd.start = 1'b1;
        ds_a = pw_q;
        ds_b = 64'(den_q) + 64'd2;
      end
      S_AS_FD: begin
        ds_cmd.start = 1'b1;
        ds_a = prod_q;
        ds_b = 64'(den_q) + 64'd1;
      end
      S_EP_P: begin
        ds_cmd.start = !pw_more;
        ds_a = ONE;
        ds_b = p_q;
      end
      default: ;
    endcase
  end

  asu_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ds_cmd),
    .a_i    (ds_a),
    .b_i    (ds_b),
    .res_o  (ds_res),
    .sts_o  (ds_sts)
  );

  // precision register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= 4'd6;
    end else if (cfg_we_i) begin
      sig_q <= cfg_wdata_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:     if (x_in.valid) state_q <= S_CLASS;
        S_CLASS: begin
          if (ax64 == 0 || ax64 >= ONE || ax64 == (ONE >> 1)) state_q <= S_FIN;
          else if (ax100 > LIM71) state_q <= S_SQ_START;
          else state_q <= S_AS_X2;
        end
        S_SQ_START: state_q <= S_SQ_WAIT;
        S_SQ_WAIT:  if (ds_sts.done) state_q <= S_T_WAIT;
        S_T_WAIT:   if (ds_sts.done) state_q <= S_AT_SEL;
        S_AT_SEL: begin
          if (t_q == 0) state_q <= S_FIN;
          else if (t_q >= $signed(ONE)) state_q <= S_AT_R2;
          else if (t_q > $signed(RED1)) state_q <= S_AT_R1M;
          else state_q <= S_AT_INIT;
        end
        S_AT_R2:    if (ds_sts.done) state_q <= S_AT_INIT;
        S_AT_R1M:   state_q <= S_AT_R1D;
        S_AT_R1D:   if (ds_sts.done) state_q <= S_AT_INIT;
        S_AT_INIT:  state_q <= S_AT_X2;
        S_AT_X2:    state_q <= S_AT_PW;
        S_AT_PW:    state_q <= S_AT_LOOP;
        S_AT_LOOP:  state_q <= S_AT_Q;
        S_AT_Q:     if (ds_sts.done) state_q <= S_PWN;
        S_AS_X2:    state_q <= S_AS_PW;
        S_AS_PW:    state_q <= S_AS_LOOP;
        S_AS_LOOP:  state_q <= S_AS_Q;
        S_AS_Q:     if (ds_sts.done) state_q <= S_AS_T;
        S_AS_T:     state_q <= S_AS_FD;
        S_AS_FD:    state_q <= S_AS_FQ;
        S_AS_FQ:    if (ds_sts.done) state_q <= S_PWN;
        S_PWN:      state_q <= have_q ? S_CHK : S_EP_K;
        S_EP_K:     if (!ep_more) state_q <= S_EP_P;
        S_EP_P:     if (!pw_more) state_q <= S_EP_D;
        S_EP_D:     if (ds_sts.done) state_q <= S_CHK;
        S_CHK: begin
          if (go_on) state_q <= path_q ? S_AT_LOOP : S_AS_LOOP;
          else state_q <= S_FIN;
        end
        S_FIN:      if (!ovalid_q || res_out.ready) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        neg_q <= x_in.x_value[31];
        ax_q  <= x_in.x_value[31] ? 32'(-x_in.x_value) : 32'(x_in.x_value);
      end
      S_CLASS: begin
        finv_q <= ax64 > ONE;
        path_q <= 1'b0;
        res_q  <= $signed(ax64);
        if (ax64 == ONE) r_q <= $signed(PI2);
        else if (ax64 == (ONE >> 1)) r_q <= $signed(PI6);
        else r_q <= '0;
      end
      S_T_WAIT: if (ds_sts.done) begin
        t_q    <= $signed(ds_res);
        path_q <= 1'b1;
      end
      S_AT_SEL: begin
        r_q    <= $signed(PI2);
        mode_q <= (t_q >= $signed(ONE)) ? 2'd2 : (t_q > $signed(RED1)) ? 2'd1 : 2'd0;
      end
      S_AT_R2:  if (ds_sts.done) t_q <= $signed(ds_res);
      S_AT_R1M: tsgn_q <= num[63];
      S_AT_R1D: if (ds_sts.done) t_q <= x_sign_q(ds_res, tsgn_q);
      S_AT_INIT: res_q <= t_q;
      S_AT_X2:  x2_q <= fxm;
      S_AT_PW: begin
        pw_q   <= fxm;
        den_q  <= DEN_W'(3);
        alt_q  <= 1'b1;
        cnt_q  <= '0;
        have_q <= 1'b0;
      end
      S_AT_LOOP, S_AS_LOOP: prev_q <= res_q;
      S_AT_Q: if (ds_sts.done) begin
        res_q <= res_q + qs;
        alt_q <= !alt_q;
        den_q <= den_q + DEN_W'(2);
      end
      S_AS_X2: x2_q <= fxm;
      S_AS_PW: begin
        pw_q   <= fxm;
        frac_q <= $signed(ONE >> 1);
        den_q  <= DEN_W'(1);
        cnt_q  <= '0;
        have_q <= 1'b0;
      end
      S_AS_T: begin
        res_q <= res_q + fxm;
        den_q <= den_q + DEN_W'(2);
      end
      S_AS_FQ: if (ds_sts.done) frac_q <= $signed(ds_res);
      S_PWN: begin
        pw_q  <= fxm;
        cnt_q <= cnt_q + CNT_W'(1);
        ev_q  <= mag(res_q);
        k_q   <= '0;
      end
      S_EP_K: begin
        if (ep_more) begin
          ev_q <= (ev_q << 3) + (ev_q << 1);
          k_q  <= k_q + asu_pkg::KW'(1);
        end else begin
          e_q <= k_q + asu_pkg::KW'(sig_q);
          p_q <= 64'd1;
          i_q <= '0;
        end
      end
      S_EP_P: if (pw_more) begin
        p_q <= (p_q << 3) + (p_q << 1);
        i_q <= i_q + asu_pkg::KW'(1);
      end
      S_EP_D: if (ds_sts.done) begin
        eps_q  <= (ds_res == 0) ? 64'd1 : ds_res;
        have_q <= 1'b1;
      end
      S_CHK: begin
        // set the result: the series sum on the asin path, else pi/2 - atan(t) with the reduction folded in
        if (!path_q) r_q <= res_q;
        else if (mode_q == 2'd2) r_q <= res_q;
        else if (mode_q == 2'd1) r_q <= $signed(PI2M6) - res_q;
        else r_q <= $signed(PI2) - res_q;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == S_FIN && (!ovalid_q || res_out.ready)) begin
      ovalid_q <= 1'b1;
    end else if (res_out.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && (!ovalid_q || res_out.ready)) begin
      angle_q    <= neg_q ? 32'(-r_q) : 32'(r_q);
      finv_out_q <= finv_q;
    end
  end

  assign x_in.ready      = (state_q == S_IDLE);
  assign res_out.valid   = ovalid_q;
  assign res_out.angle   = angle_q;
  assign res_out.invalid = finv_out_q;

  // checks
  a_ds_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_cmd.start |-> !ds_sts.busy) else $error("divider restarted while busy");

  a_term_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> cnt_q <= CNT_W'(MAX_TERMS)) else $error("term count overrun");

  a_accept_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_in.valid && x_in.ready) |=> state_q == S_CLASS) else $error("accept lost");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && res_out.invalid) |-> res_out.angle == 0)
    else $error("invalid result carries an angle");

endmodule

FILE: design/asu_divsqrt.sv
// Shared bit-serial unsigned divider and integer square root.
module asu_divsqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  asu_pkg::ds_cmd_t           cmd_i,
  input  logic [asu_pkg::DW-1:0]     a_i,
  input  logic [asu_pkg::DW-1:0]     b_i,
  output logic [asu_pkg::DW-1:0]     res_o,
  output asu_pkg::ds_sts_t           sts_o
);

  logic [asu_pkg::DW-1:0] quo_q;   // quotient, or root
  logic [asu_pkg::DW:0]   rem_q;   // remainder, or radicand left
  logic [asu_pkg::DW-1:0] div_q;
  logic [asu_pkg::DW-1:0] bb_q;
  logic [6:0]             cnt_q;
  logic                   busy_q, done_q, sqrt_q;

  logic [asu_pkg::DW:0]   rem_sh, rem_sub;
  logic                   div_ge;
  logic [asu_pkg::DW-1:0] rb;
  logic                   sq_ge;

  always_comb begin
    rem_sh  = {rem_q[asu_pkg::DW-1:0], quo_q[asu_pkg::DW-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    div_ge  = rem_sh >= {1'b0, div_q};
    rb      = quo_q + bb_q;
    sq_ge   = rem_q[asu_pkg::DW-1:0] >= rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        sqrt_q <= cmd_i.is_sqrt;
        cnt_q  <= cmd_i.is_sqrt ? 7'd32 : 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q <= cmd_i.is_sqrt ? '0 : a_i;
      rem_q <= cmd_i.is_sqrt ? {1'b0, a_i} : '0;
      div_q <= b_i;
      bb_q  <= {2'b01, {(asu_pkg::DW-2){1'b0}}};
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (sq_ge) begin
          rem_q <= {1'b0, rem_q[asu_pkg::DW-1:0] - rb};
          quo_q <= (quo_q >> 1) + bb_q;
        end else begin
          quo_q <= quo_q >> 1;
        end
        bb_q <= bb_q >> 2;
      end else begin
        rem_q <= div_ge ? rem_sub : rem_sh;
        quo_q <= {quo_q[asu_pkg::DW-2:0], div_ge};
      end
    end
  end

  assign res_o = quo_q;
  assign sts_o = '{busy: busy_q, done: done_q};

endmodule

FILE: verif/arcsine_series_unit_tb.sv
// Self-checking testbench of the arcsine series unit: directed, precision sweep and random.
module arcsine_series_unit_tb;

  localparam int unsigned FRAC = 30;
  localparam int unsigned TERMS = 64;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint PI_HALF = 64'sd1686629713;
  localparam longint PI_SIXTH = 64'sd562209904;
  localparam longint ROOT3 = 64'sd1859775393;
  localparam int IDLE_WAIT = 40;

  typedef struct packed {
    logic signed [asu_pkg::XW-1:0] angle;
    logic                          invalid;
  } asin_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [asu_pkg::SIGW-1:0] cfg_wdata_i = '0;

  asu_in_if x_if ();
  asu_out_if r_if ();

  arcsine_series_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .x_in       (x_if.sink),
    .res_out    (r_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  logic [asu_pkg::SIGW-1:0] digits_q = 4'd6;
  asin_res_t angle_q[$];
  int unsigned n_bad = 0;
  int burst_left = 0;

  // ---------------- predictor ----------------
  function automatic longint unsigned abs64(longint a);
    return a < 0 ? 64'd0 - longint'(a) : a;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint unsigned p;
    p = (abs64(a) * abs64(b)) >> FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // stop threshold from the first partial sum and the precision register
  function automatic longint unsigned stop_step(longint unsigned v);
    int unsigned k, e;
    longint unsigned p, q;
    k = 0;
    p = 1;
    while (v < longint'(ONE) && k < asu_pkg::KMAX) begin
      v *= 10;
      k++;
    end
    e = k + digits_q;
    for (int unsigned i = 0; i < e && p <= longint'(ONE); i++) p *= 10;
    q = longint'(ONE) / p;
    return q == 0 ? 1 : q;
  endfunction

  function automatic longint atan_of(longint t);
    longint sum, last, t2, pw, den, q;
    longint unsigned thr;
    bit sub, have;
    int fold, n;
    den = 3; sub = 1; have = 0; fold = 0; n = 0; thr = 0;
    if (t == 0) return 0;
    if (t >= ONE) begin
      t = (ONE * ONE) / t;
      fold = 2;
    end else if (t > 2 * ONE - ROOT3) begin
      t = ((fmul(ROOT3, t) - ONE) * ONE) / (ROOT3 + t);
      fold = 1;
    end
    sum = t;
    t2 = fmul(t, t);
    pw = fmul(t2, t);
    do begin
      last = sum;
      q = pw / den;
      sum += sub ? -q : q;
      sub = !sub;
      den += 2;
      pw = fmul(pw, t2);
      if (!have) begin
        thr = stop_step(abs64(sum));
        have = 1;
      end
      n++;
    end while (abs64(sum - last) >= thr && n < TERMS);
    if (fold == 2) return PI_HALF - sum;
    if (fold == 1) return PI_SIXTH + sum;
    return sum;
  endfunction

  function automatic longint asin_sum(longint a);
    longint sum, last, a2, pw, frac, den, step;
    longint unsigned thr;
    bit have;
    int n;
    sum = a; frac = ONE >>> 1; den = 1; have = 0; n = 0; thr = 0;
    a2 = fmul(a, a);
    pw = fmul(sum, a2);
    do begin
      last = sum;
      step = fmul(frac, pw / (den + 2));
      sum += step;
      den += 2;
      frac = (frac * den) / (den + 1);
      pw = fmul(pw, a2);
      if (!have) begin
        thr = stop_step(abs64(sum));
        have = 1;
      end
      n++;
    end while (abs64(sum - last) >= thr && n < TERMS);
    return sum;
  endfunction

  function automatic asin_res_t asin_of(logic [asu_pkg::XW-1:0] x);
    asin_res_t o;
    longint ax, r, t;
    longint unsigned s;
    o = '0;
    ax = x[asu_pkg::XW-1] ? 64'h1_0000_0000 - longint'({32'b0, x}) : longint'({32'b0, x});
    if (ax == 0) return o;
    if (ax > ONE) begin
      o.invalid = 1'b1;
      return o;
    end
    if (ax == ONE) r = PI_HALF;
    else if (ax == (ONE >>> 1)) r = PI_SIXTH;
    else if (ax * 100 > 71 * ONE) begin
      // near one: pi/2 - atan(sqrt(1 - x^2) / |x|)
      s = int_sqrt(longint'(ONE * ONE) - longint'(ax * ax));
      t = longint'((s << FRAC) / longint'(ax));
      r = PI_HALF - atan_of(t);
    end else r = asin_sum(ax);
    if (x[asu_pkg::XW-1]) r = -r;
    o.angle = r[asu_pkg::XW-1:0];
    return o;
  endfunction

  // ---------------- result side ----------------
  // receiver stalls follow a mode that changes every so often
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: r_if.ready <= 1'b1;
      1: r_if.ready <= ($urandom_range(0, 3) != 0);
      2: r_if.ready <= ($urandom_range(0, 3) == 0);
      default: r_if.ready <= (r_if.ready !== 1'b1);
    endcase
  end

  always @(posedge clk_i) begin
    asin_res_t exp_r;
    if (rst_ni && r_if.valid && r_if.ready) begin
      if (angle_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result transfer: angle %0d invalid %0b",
                                  r_if.angle, r_if.invalid);
      end else begin
        exp_r = angle_q.pop_front();
        if (r_if.angle !== exp_r.angle || r_if.invalid !== exp_r.invalid) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: angle exp %0d got %0d, invalid exp %0b got %0b",
                     exp_r.angle, r_if.angle, exp_r.invalid, r_if.invalid);
        end
      end
    end
  end

  // ---------------- stimulus side ----------------
  initial begin
    x_if.valid = 1'b0;
    x_if.x_value = '0;
  end

  // one argument transfer; valid stays up across a burst
  task automatic send_x(logic [asu_pkg::XW-1:0] x);
    if (burst_left == 0) begin
      x_if.valid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    x_if.valid = 1'b1;
    x_if.x_value = x;
    do @(posedge clk_i); while (!x_if.ready);
    angle_q.push_back(asin_of(x));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    x_if.valid = 1'b0;
    burst_left = 0;
    while (angle_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_WAIT) @(negedge clk_i);
  endtask

  task automatic set_digits(logic [asu_pkg::SIGW-1:0] d);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    digits_q = d;
  endtask

  function automatic logic [asu_pkg::XW-1:0] pick_x();
    logic [asu_pkg::XW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom();                                        // any bit pattern
      1: v = $urandom_range(0, 32'h4000_0000);                  // [0, 1]
      2: v = $urandom_range(32'h2D70_A3D7, 32'h4000_0000);      // near-one branch
      3: v = $urandom_range(0, 32'h2D70_A3D8);                  // series branch
      4: v = $urandom_range(0, 1023);                           // tiny
      5: v = 32'h4000_0000 + $urandom_range(0, 4) - 2;          // around one
      6: v = 32'h2000_0000 + $urandom_range(0, 4) - 2;          // around one half
      7: v = 32'h2D70_A3D7 + $urandom_range(0, 4) - 2;          // branch edge
      default: v = $urandom_range(1, 32'h4000_0000);
    endcase
    if (v[asu_pkg::XW-1] == 1'b0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic test_specials();
    logic [asu_pkg::XW-1:0] xs[] = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h2000_0000,
                             32'hE000_0000, 32'h4000_0001, 32'hBFFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF,
                             32'hC000_0001, 32'h2D70_A3D7, 32'h2D70_A3D8,
                             32'h1FFF_FFFF, 32'h2000_0001, 32'h0000_0001,
                             32'hFFFF_FFFF, 32'h1000_0000, 32'h3800_0000,
                             32'h3FFF_F000, 32'hFFFF_FFFE};
    foreach (xs[i]) send_x(xs[i]);
  endtask

  // precision register extremes and in between, including out-of-range codes
  task automatic test_precision();
    logic [asu_pkg::SIGW-1:0] ds[] = '{4'd1, 4'd9, 4'd0, 4'd15, 4'd3};
    foreach (ds[i]) begin
      set_digits(ds[i]);
      send_x(32'h2D70_A3D7);
      send_x(32'h3F00_0000);
      send_x(32'h0123_4567);
      send_x(32'hE800_0000);
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 9; p++) begin
      set_digits(p == 0 ? 4'd6 : asu_pkg::SIGW'($urandom_range(0, 15)));
      for (int i = 0; i < 150; i++) send_x(pick_x());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_specials();
    test_precision();
    test_random();
    drain();
    if (n_bad == 0 && angle_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
